/* rtl/core/awtf_pkg.sv */
// Package: shared constants, types and state encoding for the translation fit.
package awtf_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam int unsigned NUM_W  = 77;  // signed numerator
    localparam int unsigned DET_W  = 55;  // signed determinant
    localparam int unsigned MAG_W  = NUM_W - 1;
    localparam int unsigned DMAG_W = DET_W;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_ACC,
        S_DET_A,
        S_DET_B,
        S_NUM,
        S_DIV,
        S_OUT
    } t_state;

    // One classified point: displacement and weights.
    typedef struct packed {
        logic signed [16:0] ddx;
        logic signed [16:0] ddy;
        logic        [15:0] wxx;
        logic signed [15:0] wxy;
        logic        [15:0] wyy;
        logic               last;
    } t_item;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

/* rtl/core/awtf_if.sv */
// Interfaces: point-pair input channel and fit result channel.
interface awtf_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic        [15:0] weight_xx;
    logic signed [15:0] weight_xy;
    logic        [15:0] weight_yy;
    logic               last_point;

    modport source (output valid, src_x, src_y, dst_x, dst_y, weight_xx, weight_xy,
                    weight_yy, last_point, input ready);
    modport sink   (input valid, src_x, src_y, dst_x, dst_y, weight_xx, weight_xy,
                    weight_yy, last_point, output ready);
endinterface

interface awtf_fit_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] shift_x;
    logic signed [16:0] shift_y;
    logic        [1:0]  fit_status;

    modport source (output valid, shift_x, shift_y, fit_status, input ready);
    modport sink   (input valid, shift_x, shift_y, fit_status, output ready);
endinterface

/* rtl/core/anisotropic_weighted_translation_fit_top.sv */
// Top level: weighted 2-D translation fit, front queue plus accumulate/solve back end.
// Throughput: one point pair per cycle while accumulating; queue of four decouples input.
// Solve: a last point passes the queue, then the determinant states S_DET_A and S_DET_B, then
// per axis 4 numerator products and 76 divide steps; the result loads once the output has room.
// The shared divide sequencer sets the solve time; accumulation is one multiply-add set.
// Reset (synchronous, active low) clears the queue, all sums, the point count and the result valid flag.
module anisotropic_weighted_translation_fit_top #(
    parameter int unsigned MAX_POINTS = awtf_pkg::MAX_POINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    awtf_pt_if.sink    i_pt,
    awtf_fit_if.source o_fit
);
    import awtf_pkg::*;

    t_queue_head head;
    logic        pop;
    logic        out_valid;
    logic signed [16:0] out_x;
    logic signed [16:0] out_y;
    logic [1:0]  out_st;

    awtf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_pop   (pop),
        .o_head  (head)
    );

    awtf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (out_valid),
        .i_ready      (o_fit.ready),
        .o_shift_x    (out_x),
        .o_shift_y    (out_y),
        .o_fit_status (out_st)
    );

    assign o_fit.valid      = out_valid;
    assign o_fit.shift_x    = out_x;
    assign o_fit.shift_y    = out_y;
    assign o_fit.fit_status = out_st;

`ifndef SYNTHESIS
    // A queued transaction not popped stays queued
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head.valid && !pop |=> head.valid)
        else $error("queued transaction lost");

    // Error status always comes with zero translation
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && (out_st != ST_OK) |-> (out_x == '0) && (out_y == '0))
        else $error("error status with nonzero translation");

    // Status code is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_st == ST_OK) || (out_st == ST_SINGULAR) ||
                      (out_st == ST_TOO_MANY))
        else $error("undefined status code");
`endif

endmodule

/* rtl/core/awtf_front.sv */
// Front end: accepts point pairs, forms displacements, buffers them in a short queue.
module awtf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    awtf_pt_if.sink                   i_pt,
    input  logic                      i_pop,
    output awtf_pkg::t_queue_head     o_head
);
    import awtf_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;
    logic                push;
    logic                pop;
    t_item               item;

    // Classify: displacement in Q13.4
    always_comb begin
        item.ddx  = 17'(i_pt.dst_x) - 17'(i_pt.src_x);
        item.ddy  = 17'(i_pt.dst_y) - 17'(i_pt.src_y);
        item.wxx  = i_pt.weight_xx;
        item.wxy  = i_pt.weight_xy;
        item.wyy  = i_pt.weight_yy;
        item.last = i_pt.last_point;
    end

    assign i_pt.ready   = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push         = i_pt.valid && i_pt.ready;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/awtf_back.sv */
// Back end: accumulates weighted sums, solves the 2x2 system, holds the result.
module awtf_back #(
    parameter int unsigned MAX_POINTS = awtf_pkg::MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  awtf_pkg::t_queue_head     i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [16:0]        o_shift_x,
    output logic signed [16:0]        o_shift_y,
    output logic [1:0]                o_fit_status
);
    import awtf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_POINTS + 2);

    t_state                  r_state, n_state;
    logic signed [25:0]      r_sxx;
    logic signed [26:0]      r_sxy;
    logic signed [25:0]      r_syy;
    logic signed [47:0]      r_bx;
    logic signed [47:0]      r_by;
    logic [CW-1:0]           r_cnt;
    logic signed [NUM_W-1:0] r_acc;
    logic signed [DET_W-1:0] r_det;
    logic [DMAG_W-1:0]       r_dmag;
    logic                    r_axis;
    logic [1:0]              r_step;
    logic [MAG_W-1:0]        r_nmag;
    logic [DMAG_W-1:0]       r_rem;
    logic [16:0]             r_quo;
    logic                    r_over;
    logic                    r_neg;
    logic [6:0]              r_dcnt;
    logic signed [16:0]      r_tx;
    logic signed [16:0]      r_ty;
    logic [1:0]              r_st;
    logic                    r_ov;
    logic signed [16:0]      r_ox;
    logic signed [16:0]      r_oy;
    logic [1:0]              r_ost;

    logic                    in_room;
    logic                    at_cap;
    logic                    load;
    t_item                   it;

    // Per-point products
    logic signed [33:0]      m_a, m_b, m_c, m_d;
    logic signed [34:0]      t_dx, t_dy;

    // Solve datapath
    logic signed [51:0]      det_p;
    logic signed [53:0]      det_q;
    logic signed [DET_W-1:0] n_det;
    logic signed [26:0]      op_a;
    logic signed [47:0]      op_b;
    logic signed [24:0]      op_chunk;
    logic signed [51:0]      prod;
    logic signed [NUM_W-1:0] term;
    logic signed [NUM_W-1:0] n_acc;
    logic [DMAG_W:0]         rem2;
    logic                    ge;
    logic [DMAG_W-1:0]       n_rem;
    logic [16:0]             n_quo;
    logic                    n_over;
    logic signed [16:0]      sat;

    assign it      = i_head.item;
    assign at_cap  = (r_cnt >= CW'(MAX_POINTS));
    assign in_room = !r_ov || i_ready;

    // Point accumulation terms
    assign m_a  = $signed({1'b0, it.wxx}) * it.ddx;
    assign m_b  = it.wxy * it.ddy;
    assign m_c  = it.wxy * it.ddx;
    assign m_d  = $signed({1'b0, it.wyy}) * it.ddy;
    assign t_dx = 35'(m_a) + 35'(m_b);
    assign t_dy = 35'(m_c) + 35'(m_d);

    // Determinant pieces
    assign det_p = r_sxx * r_syy;
    assign det_q = r_sxy * r_sxy;
    assign n_det = r_acc[DET_W-1:0] - DET_W'(det_q);

    // Numerator partial products: p*q - r*s, 24-bit chunks of the long operand
    always_comb begin
        if (r_step[1]) begin
            op_a = r_sxy;
            op_b = r_axis ? r_bx : r_by;
        end else begin
            op_a = r_axis ? 27'(r_sxx) : 27'(r_syy);
            op_b = r_axis ? r_by : r_bx;
        end
        op_chunk = r_step[0] ? 25'($signed(op_b[47:24])) : $signed({1'b0, op_b[23:0]});
        prod     = op_a * op_chunk;
        term     = r_step[0] ? (NUM_W'(prod) <<< 24) : NUM_W'(prod);
        n_acc    = r_step[1] ? r_acc - term : r_acc + term;
    end

    // Restoring division step, with saturation of the finished quotient
    always_comb begin
        rem2   = {r_rem, r_nmag[MAG_W-1]};
        ge     = (rem2 >= {1'b0, r_dmag});
        n_rem  = ge ? DMAG_W'(rem2 - {1'b0, r_dmag}) : rem2[DMAG_W-1:0];
        n_quo  = {r_quo[15:0], ge};
        n_over = r_over || r_quo[16];
        if (r_neg) begin
            sat = (n_over || (n_quo > 17'd65536)) ? -17'sd65536 : -$signed(n_quo);
        end else begin
            sat = (n_over || (n_quo > 17'd65535)) ? 17'sd65535 : $signed(n_quo);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC: begin
                if (i_head.valid && it.last) n_state = at_cap ? S_OUT : S_DET_A;
            end
            S_DET_A: n_state = S_DET_B;
            S_DET_B: n_state = (n_det == '0) ? S_OUT : S_NUM;
            S_NUM:   n_state = (r_step == 2'd3) ? S_DIV : S_NUM;
            S_DIV: begin
                if (r_dcnt == '0) n_state = r_axis ? S_OUT : S_NUM;
            end
            S_OUT: begin
                if (in_room) n_state = S_ACC;
            end
            default: n_state = S_ACC;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        unique case (r_state)
            S_ACC:   o_pop = i_head.valid;
            S_OUT:   load  = in_room;
            default: begin
                o_pop = 1'b0;
                load  = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_syy   <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (load) begin
                r_cnt <= '0;
                r_sxx <= '0;
                r_sxy <= '0;
                r_syy <= '0;
                r_bx  <= '0;
                r_by  <= '0;
            end else if (o_pop) begin
                if (at_cap) begin
                    r_cnt <= CW'(MAX_POINTS + 1);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sxx <= r_sxx + 26'({1'b0, it.wxx});
                    r_sxy <= r_sxy + 27'(it.wxy);
                    r_syy <= r_syy + 26'({1'b0, it.wyy});
                    r_bx  <= r_bx + 48'(t_dx);
                    r_by  <= r_by + 48'(t_dy);
                end
            end
        end
    end

    // Solve datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_ACC: begin
                if (o_pop && it.last && at_cap) begin
                    r_st <= ST_TOO_MANY;
                    r_tx <= '0;
                    r_ty <= '0;
                end
            end
            S_DET_A: r_acc <= NUM_W'(det_p);
            S_DET_B: begin
                r_det  <= n_det;
                r_dmag <= n_det[DET_W-1] ? DMAG_W'(-n_det) : DMAG_W'(n_det);
                r_axis <= 1'b0;
                r_step <= '0;
                r_acc  <= '0;
                r_st   <= (n_det == '0) ? ST_SINGULAR : ST_OK;
                r_tx   <= '0;
                r_ty   <= '0;
            end
            S_NUM: begin
                r_acc  <= n_acc;
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_nmag <= n_acc[NUM_W-1] ? MAG_W'(-n_acc) : MAG_W'(n_acc);
                    r_neg  <= n_acc[NUM_W-1] ^ r_det[DET_W-1];
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_over <= 1'b0;
                    r_dcnt <= 7'(MAG_W - 1);
                end
            end
            S_DIV: begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_over <= n_over;
                r_nmag <= r_nmag << 1;
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    if (r_axis) begin
                        r_ty <= sat;
                    end else begin
                        r_tx <= sat;
                    end
                    r_axis <= 1'b1;
                    r_step <= '0;
                    r_acc  <= '0;
                end
            end
            S_OUT: begin
                if (load) begin
                    r_ox  <= r_tx;
                    r_oy  <= r_ty;
                    r_ost <= r_st;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_valid      = r_ov;
    assign o_shift_x    = r_ox;
    assign o_shift_y    = r_oy;
    assign o_fit_status = r_ost;

endmodule

/* tb/awtf_fit_checker.sv */
// Checker: watches both channels, predicts each fit result and compares it.
module awtf_fit_checker #(
    parameter int unsigned MAX_POINTS = awtf_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    awtf_pt_if          i_pt,
    awtf_fit_if         i_fit,
    output int unsigned o_errors,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import awtf_pkg::*;

    typedef struct packed {
        logic signed [16:0] shift_x;
        logic signed [16:0] shift_y;
        t_status            status;
    } t_fit;

    // running sums of the current point set
    logic signed [25:0] acc_wxx, acc_wyy;
    logic signed [26:0] acc_wxy;
    logic signed [47:0] acc_bx, acc_by;
    int unsigned        pts;
    t_fit               fits_due[$];

    // (p*q - r*s) / det, truncated toward zero, saturated to 17 bits
    function automatic logic signed [16:0] solve_axis(
        input logic signed [63:0] p, q, r, s, det);
        logic signed [127:0] num, quo;
        num = 128'(p) * 128'(q) - 128'(r) * 128'(s);
        quo = num / 128'(det);
        if (quo > 65535) return 17'sd65535;
        if (quo < -65536) return -17'sd65536;
        return quo[16:0];
    endfunction

    task automatic report(input string what, input logic [63:0] got, exp_v);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(exp_v));
        o_errors++;
    endtask

    assign o_pending = fits_due.size();

    always @(posedge i_clk) begin
        logic signed [16:0] dx, dy;
        logic signed [47:0] tx, ty;
        logic signed [63:0] det;
        t_fit f, got;
        if (!i_rst_n) begin
            acc_wxx <= '0; acc_wxy <= '0; acc_wyy <= '0;
            acc_bx <= '0; acc_by <= '0; pts = 0; o_errors = 0;
        end else begin
            // check a result transaction against the oldest prediction
            if (i_fit.valid && i_fit.ready) begin
                got = '{i_fit.shift_x, i_fit.shift_y, t_status'(i_fit.fit_status)};
                if (fits_due.size() == 0) begin
                    report("unexpected result", 64'(got.status), 64'(0));
                end else begin
                    f = fits_due.pop_front();
                    if (got.shift_x !== f.shift_x) report("shift_x", 64'(got.shift_x), 64'(f.shift_x));
                    if (got.shift_y !== f.shift_y) report("shift_y", 64'(got.shift_y), 64'(f.shift_y));
                    if (got.status !== f.status) report("status", 64'(got.status), 64'(f.status));
                end
            end
            // accumulate an input transaction
            if (i_pt.valid && i_pt.ready) begin
                logic signed [25:0] nxx, nyy;
                logic signed [26:0] nxy;
                logic signed [47:0] nbx, nby;
                nxx = acc_wxx; nxy = acc_wxy; nyy = acc_wyy; nbx = acc_bx; nby = acc_by;
                if (pts < MAX_POINTS) begin
                    dx = 17'(i_pt.dst_x) - 17'(i_pt.src_x);
                    dy = 17'(i_pt.dst_y) - 17'(i_pt.src_y);
                    tx = 48'($signed({1'b0, i_pt.weight_xx})) * 48'(dx)
                       + 48'(i_pt.weight_xy) * 48'(dy);
                    ty = 48'(i_pt.weight_xy) * 48'(dx)
                       + 48'($signed({1'b0, i_pt.weight_yy})) * 48'(dy);
                    nxx = nxx + 26'(i_pt.weight_xx);
                    nxy = nxy + 27'(i_pt.weight_xy);
                    nyy = nyy + 26'(i_pt.weight_yy);
                    nbx = nbx + tx; nby = nby + ty;
                    pts++;
                end else begin
                    pts = MAX_POINTS + 1;
                end
                if (i_pt.last_point) begin
                    f = '{17'sd0, 17'sd0, ST_OK};
                    det = 64'(nxx) * 64'(nyy) - 64'(nxy) * 64'(nxy);
                    if (pts > MAX_POINTS) f.status = ST_TOO_MANY;
                    else if (det == 0) f.status = ST_SINGULAR;
                    else begin
                        f.shift_x = solve_axis(64'(nyy), 64'(nbx), 64'(nxy), 64'(nby), det);
                        f.shift_y = solve_axis(64'(nxx), 64'(nby), 64'(nxy), 64'(nbx), det);
                    end
                    fits_due.push_back(f);
                    nxx = '0; nxy = '0; nyy = '0; nbx = '0; nby = '0; pts = 0;
                end
                acc_wxx <= nxx; acc_wxy <= nxy; acc_wyy <= nyy;
                acc_bx <= nbx; acc_by <= nby;
            end
        end
    end
endmodule

/* tb/anisotropic_weighted_translation_fit_top_tb.sv */
// Testbench top: point-set stimulus, random stalls, watchdog and verdict.
module anisotropic_weighted_translation_fit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import awtf_pkg::*;

    localparam int unsigned WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count, fits_pending, idle_cycles;

    awtf_pt_if  pt_ch();
    awtf_fit_if fit_ch();

    anisotropic_weighted_translation_fit_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_ch.sink), .o_fit(fit_ch.source));

    awtf_fit_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_ch), .i_fit(fit_ch),
        .o_errors(fail_count), .o_pending(fits_pending));

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // random pick biased toward field extremes
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // send one point pair, optionally pausing first for a random gap; valid stays up for a following send
    task automatic send_point(input logic [15:0] sx, sy, dx, dy, wxx, wxy, wyy,
                              input logic last);
        int unsigned gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.src_x <= sx; pt_ch.src_y <= sy; pt_ch.dst_x <= dx; pt_ch.dst_y <= dy;
        pt_ch.weight_xx <= wxx; pt_ch.weight_xy <= wxy; pt_ch.weight_yy <= wyy;
        pt_ch.last_point <= last;
        do @(posedge i_clk); while (!pt_ch.ready);
    endtask

    task automatic send_random(input logic last);
        send_point(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                   last);
    endtask

    // drop valid and hold off until every predicted fit has come back
    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (fits_pending == 0);
    endtask

    // result side: a random stall, possibly none, before each result is taken
    initial begin
        int unsigned gap;
        fit_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                fit_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            fit_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!fit_ch.valid);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (fit_ch.valid && fit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned sent, n;
        i_rst_n = 1'b0;
        idle_cycles = 0;
        pt_ch.valid = 1'b0; pt_ch.last_point = 1'b0;
        {pt_ch.src_x, pt_ch.src_y, pt_ch.dst_x, pt_ch.dst_y} = '0;
        {pt_ch.weight_xx, pt_ch.weight_xy, pt_ch.weight_yy} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity weights, extremes, singular, indefinite, empty weights
        send_point(16'h0000, 16'h0000, 16'h0010, 16'hFFF0, 16'h0100, 16'h0000, 16'h0100, 1);
        send_point(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 0);
        send_point(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF, 1);
        send_point(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 1);
        send_point(16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0100, 16'h0100, 16'h0100, 1);
        send_point(16'h0000, 16'h0000, 16'h0050, 16'h0020, 16'h0000, 16'h0100, 16'h0000, 1);
        send_point(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000, 16'h0001, 1);
        send_point(16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h0001, 0);
        send_point(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 16'h8001, 16'h0001, 1);
        sent = 9;

        // too many points: one set just over the limit
        for (int k = 0; k < MAX_POINTS_DEF + 1; k++) send_random(k == MAX_POINTS_DEF);
        sent += MAX_POINTS_DEF + 1;

        // hold off until every fit has come back
        drain();

        // random sets, mostly short
        while (sent < 1450) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
            for (int k = 0; k < n; k++) send_random(k == n - 1);
            sent += n;
            if ($urandom_range(0, 30) == 0) drain();
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
rtl/core/awtf_pkg.sv
rtl/core/awtf_if.sv
rtl/core/awtf_front.sv
rtl/core/awtf_back.sv
rtl/core/anisotropic_weighted_translation_fit_top.sv
tb/awtf_fit_checker.sv
tb/anisotropic_weighted_translation_fit_top_tb.sv
